// ===== rtl/clsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsr_pkg: combined LCG shuffled random source, shared definitions
// Constants of the two generators, controller states, the command and
// status groups between controller and datapath, and the modular fold.
// ----------------------------------------------------------------------------
package clsr_pkg;

   localparam int VAL_W  = 31;
   localparam int PROD_W = 47;

   localparam logic [VAL_W-1:0] MOD_A        = 31'd2147483563;
   localparam logic [VAL_W-1:0] MOD_B        = 31'd2147483399;
   localparam logic [15:0]      MUL_A        = 16'd40014;
   localparam logic [15:0]      MUL_B        = 16'd40692;
   // 2^31 - modulus, used to fold the product's upper part back in
   localparam logic [7:0]       FOLD_A       = 8'd85;
   localparam logic [7:0]       FOLD_B       = 8'd249;
   localparam logic [VAL_W-1:0] SEED_B_RESET = 31'd123456789;
   localparam int               WARMUP_STEPS = 8;

   localparam logic CMD_DRAW   = 1'b0;
   localparam logic CMD_RESEED = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL_MUL,
      ST_FILL_RED,
      ST_DRAW_MUL,
      ST_DRAW_RED,
      ST_DRAW_OUT
   } state_type;

   typedef struct packed {
      logic load_seed;
      logic mult;
      logic reduce_a;
      logic reduce_b;
      logic fill_write;
      logic table_read;
      logic draw_commit;
   } cmd_type;

   typedef struct packed {
      logic fill_last;
      logic out_free;
   } sts_type;

   // p mod (2^31 - c), valid for p < 2^47: hi*c + lo stays below twice the modulus
   function automatic logic [VAL_W-1:0] mod_fold(input logic [PROD_W-1:0] p,
                                                 input logic [7:0]        c,
                                                 input logic [VAL_W-1:0]  m);
      logic [31:0] folded;
      logic [31:0] reduced;
      folded  = {1'b0, p[VAL_W-1:0]} + 32'(p[PROD_W-1:VAL_W] * c);
      reduced = folded - {1'b0, m};
      if (folded >= {1'b0, m}) begin
         return reduced[VAL_W-1:0];
      end
      return folded[VAL_W-1:0];
   endfunction

endpackage

// ===== rtl/clsr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsr_if: request and response channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface clsr_req_if;
   logic                        valid;
   logic                        ready;
   logic                        cmd;
   logic [clsr_pkg::VAL_W-1:0]  seed;

   modport source(output valid, cmd, seed, input ready);
   modport sink(input valid, cmd, seed, output ready);
endinterface

interface clsr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [clsr_pkg::VAL_W-1:0]  value;

   modport source(output valid, value, input ready);
   modport sink(input valid, value, output ready);
endinterface

// ===== rtl/clsr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsr_ctrl: sequencer
// Steps the datapath through the reseed fill loop and the draw sequence.
// ----------------------------------------------------------------------------
module clsr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid_i,
   input  logic               req_cmd_i,
   output logic               req_ready_o,
   input  clsr_pkg::sts_type  sts_i,
   output clsr_pkg::cmd_type  cmd_o
);

   clsr_pkg::state_type state_ff;
   clsr_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clsr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready_o = 1'b0;
      cmd_o       = '0;
      case (state_ff)
         clsr_pkg::ST_IDLE: begin
            req_ready_o = 1'b1;
            if (req_valid_i) begin
               if (req_cmd_i == clsr_pkg::CMD_RESEED) begin
                  cmd_o.load_seed = 1'b1;
                  state_in        = clsr_pkg::ST_FILL_MUL;
               end else begin
                  state_in = clsr_pkg::ST_DRAW_MUL;
               end
            end
         end
         clsr_pkg::ST_FILL_MUL: begin
            cmd_o.mult = 1'b1;
            state_in   = clsr_pkg::ST_FILL_RED;
         end
         clsr_pkg::ST_FILL_RED: begin
            cmd_o.reduce_a   = 1'b1;
            cmd_o.fill_write = 1'b1;
            state_in = sts_i.fill_last ? clsr_pkg::ST_DRAW_MUL : clsr_pkg::ST_FILL_MUL;
         end
         clsr_pkg::ST_DRAW_MUL: begin
            cmd_o.mult       = 1'b1;
            cmd_o.table_read = 1'b1;
            state_in         = clsr_pkg::ST_DRAW_RED;
         end
         clsr_pkg::ST_DRAW_RED: begin
            cmd_o.reduce_a = 1'b1;
            cmd_o.reduce_b = 1'b1;
            state_in       = clsr_pkg::ST_DRAW_OUT;
         end
         clsr_pkg::ST_DRAW_OUT: begin
            // hold until the output register can take the result
            if (sts_i.out_free) begin
               cmd_o.draw_commit = 1'b1;
               state_in          = clsr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = clsr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/clsr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsr_datapath: generators, shuffle table and output register
// Two modular multipliers with a fold stage, the shuffle memory with
// per-entry valid bits, slot selection and the output wrap.
// ----------------------------------------------------------------------------
module clsr_datapath #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  clsr_pkg::cmd_type           cmd_i,
   output clsr_pkg::sts_type           sts_o,
   input  logic [clsr_pkg::VAL_W-1:0]  seed_i,
   input  logic                        rsp_ready_i,
   output logic                        rsp_valid_o,
   output logic [clsr_pkg::VAL_W-1:0]  rsp_value_o
);

   localparam int SlotW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CntW  = $clog2(TABLE_DEPTH + clsr_pkg::WARMUP_STEPS);
   localparam logic [31:0] SlotDiv = 32'(1 + (clsr_pkg::MOD_A - 1) / TABLE_DEPTH);
   localparam logic [CntW-1:0] FillStart =
      CntW'(TABLE_DEPTH + clsr_pkg::WARMUP_STEPS - 1);

   logic [clsr_pkg::VAL_W-1:0]  gen_a_ff, gen_a_in;
   logic [clsr_pkg::VAL_W-1:0]  gen_b_ff, gen_b_in;
   logic [clsr_pkg::VAL_W-1:0]  last_ff, last_in;
   logic [CntW-1:0]             cnt_ff, cnt_in;
   logic [TABLE_DEPTH-1:0]      valid_ff, valid_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [clsr_pkg::VAL_W-1:0]  rsp_value_ff;
   logic [clsr_pkg::PROD_W-1:0] prod_a_ff, prod_b_ff;
   logic [SlotW-1:0]            slot_ff;
   logic [clsr_pkg::VAL_W-1:0]  rd_data_ff;
   logic                        rd_valid_ff;

   logic [clsr_pkg::VAL_W-1:0]  mem [TABLE_DEPTH];

   logic [clsr_pkg::VAL_W-1:0]  seed_fix;
   logic [clsr_pkg::VAL_W-1:0]  red_a, red_b;
   logic [SlotW-1:0]            slot_calc;
   logic [clsr_pkg::VAL_W-1:0]  tbl_val;
   logic [32:0]                 diff_lo, diff_hi;
   logic [clsr_pkg::VAL_W-1:0]  draw_val;
   logic                        fill_hit;
   logic                        wr_en;
   logic [SlotW-1:0]            wr_addr;
   logic [clsr_pkg::VAL_W-1:0]  wr_data;

   always_comb begin
      seed_fix = (seed_i == '0) ? clsr_pkg::VAL_W'(1) : seed_i;
      red_a    = clsr_pkg::mod_fold(prod_a_ff, clsr_pkg::FOLD_A, clsr_pkg::MOD_A);
      red_b    = clsr_pkg::mod_fold(prod_b_ff, clsr_pkg::FOLD_B, clsr_pkg::MOD_B);

      // slot = last / SlotDiv, clamped: highest boundary the last output reaches
      slot_calc = '0;
      for (int k = 1; k < TABLE_DEPTH; k++) begin
         if ({1'b0, last_ff} >= 32'(k) * SlotDiv) begin
            slot_calc = SlotW'(k);
         end
      end

      tbl_val  = rd_valid_ff ? rd_data_ff : '0;
      diff_lo  = {2'b00, tbl_val} - {2'b00, gen_b_ff};
      diff_hi  = diff_lo + 33'(clsr_pkg::MOD_A - 1'b1);
      draw_val = (diff_lo[32] || diff_lo == '0) ? diff_hi[clsr_pkg::VAL_W-1:0]
                                                : diff_lo[clsr_pkg::VAL_W-1:0];
      fill_hit = cnt_ff < CntW'(TABLE_DEPTH);

      gen_a_in     = gen_a_ff;
      gen_b_in     = gen_b_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_data      = gen_a_ff;

      if (rsp_valid_ff && rsp_ready_i) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd_i.load_seed) begin
         gen_a_in = seed_fix;
         gen_b_in = seed_fix;
         cnt_in   = FillStart;
      end
      if (cmd_i.reduce_a) begin
         gen_a_in = red_a;
      end
      if (cmd_i.reduce_b) begin
         gen_b_in = red_b;
      end
      if (cmd_i.fill_write) begin
         cnt_in = cnt_ff - 1'b1;
         if (fill_hit) begin
            wr_en                        = 1'b1;
            wr_addr                      = cnt_ff[SlotW-1:0];
            wr_data                      = red_a;
            valid_in[cnt_ff[SlotW-1:0]]  = 1'b1;
         end
         if (cnt_ff == '0) begin
            last_in = red_a;
         end
      end
      if (cmd_i.draw_commit) begin
         // refill the slot with the new first generator value
         wr_en             = 1'b1;
         valid_in[slot_ff] = 1'b1;
         last_in           = draw_val;
         rsp_valid_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_a_ff     <= clsr_pkg::VAL_W'(1);
         gen_b_ff     <= clsr_pkg::SEED_B_RESET;
         last_ff      <= '0;
         cnt_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gen_a_ff     <= gen_a_in;
         gen_b_ff     <= gen_b_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.mult) begin
         prod_a_ff <= clsr_pkg::PROD_W'(gen_a_ff) * clsr_pkg::PROD_W'(clsr_pkg::MUL_A);
         prod_b_ff <= clsr_pkg::PROD_W'(gen_b_ff) * clsr_pkg::PROD_W'(clsr_pkg::MUL_B);
      end
      if (cmd_i.draw_commit) begin
         rsp_value_ff <= draw_val;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd_i.table_read) begin
         rd_data_ff  <= mem[slot_calc];
         rd_valid_ff <= valid_ff[slot_calc];
         slot_ff     <= slot_calc;
      end
   end

   assign sts_o.fill_last = (cnt_ff == '0);
   assign sts_o.out_free  = !rsp_valid_ff || rsp_ready_i;
   assign rsp_valid_o     = rsp_valid_ff;
   assign rsp_value_o     = rsp_value_ff;

`ifndef SYNTHESIS
   a_gen_a_range: assert property (@(posedge clock) disable iff (reset)
      cmd_i.reduce_a |=> gen_a_ff < clsr_pkg::MOD_A)
      else $error("first generator left its range after a step");

   a_gen_b_range: assert property (@(posedge clock) disable iff (reset)
      cmd_i.reduce_b |=> gen_b_ff < clsr_pkg::MOD_B)
      else $error("second generator left its range after a step");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd_i.draw_commit))
      else $error("response raised without a draw commit");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_value_ff != '0 && rsp_value_ff < clsr_pkg::MOD_A))
      else $error("response value out of range");
`endif

endmodule

// ===== rtl/combined_lcg_shuffled_random_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combined_lcg_shuffled_random_top: combined LCG random source with shuffle
// Two multiplicative congruential generators feed a shuffle table; each
// request returns one draw, optionally after reseeding.
//
//   channel  dir  fields            meaning
//   req_ch   in   cmd, seed[30:0]   0 = draw, 1 = reseed then draw
//   rsp_ch   out  value[30:0]       draw in 1 .. 2147483562
//
// A draw steps through a multiply state, a fold state and an output state, in which
// the wrap result is committed to the output register; the next request is taken in idle.
// A reseed first steps the first generator through the warm-up and the table fill.
// Reset clears the table valid bits at once; no clearing pass is needed.
// The result waits in an output register; the next request is taken while it
// waits, and a draw that finishes before it is taken holds until then.
// ----------------------------------------------------------------------------
module combined_lcg_shuffled_random_top #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   clsr_req_if.sink     req_ch,
   clsr_rsp_if.source   rsp_ch
);

   clsr_pkg::cmd_type cmd;
   clsr_pkg::sts_type sts;

   clsr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid_i (req_ch.valid),
      .req_cmd_i   (req_ch.cmd),
      .req_ready_o (req_ch.ready),
      .sts_i       (sts),
      .cmd_o       (cmd)
   );

   clsr_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd_i       (cmd),
      .sts_o       (sts),
      .seed_i      (req_ch.seed),
      .rsp_ready_i (rsp_ch.ready),
      .rsp_valid_o (rsp_ch.valid),
      .rsp_value_o (rsp_ch.value)
   );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for combined_lcg_shuffled_random_top
// Drives draw and reseed requests over the request channel, predicts every
// draw with a behavioral copy of the two generators and the shuffle table,
// and checks each response transfer in order. Both channels idle and stall
// in random bursts except during the final stretch.
// ----------------------------------------------------------------------------
module tb;

   localparam int     TBL_DEPTH  = 32;
   localparam longint SLOT_DIV   = 1 + (longint'(clsr_pkg::MOD_A) - 1) / TBL_DEPTH;
   localparam int     CYCLE_CAP  = 600000;
   localparam int     TAIL_WAIT  = 2 * (TBL_DEPTH + clsr_pkg::WARMUP_STEPS) + 20;
   localparam int     PRINT_CAP  = 50;

   logic clock;
   logic reset;

   clsr_req_if req_ch();
   clsr_rsp_if rsp_ch();

   combined_lcg_shuffled_random_top #(
      .TABLE_DEPTH(TBL_DEPTH)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // predicted generator state
   logic [clsr_pkg::VAL_W-1:0] gen_a;
   logic [clsr_pkg::VAL_W-1:0] gen_b;
   logic [clsr_pkg::VAL_W-1:0] prev_value;
   logic [clsr_pkg::VAL_W-1:0] shuffle [TBL_DEPTH];

   logic [clsr_pkg::VAL_W-1:0] pending_values [$];
   int                         errors     = 0;
   int                         cycles     = 0;
   int                         stall_left = 0;
   logic                       idle_on;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_CAP) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [clsr_pkg::VAL_W-1:0] mul_mod(
      input logic [clsr_pkg::VAL_W-1:0] x,
      input logic [15:0]                m,
      input logic [clsr_pkg::VAL_W-1:0] n);
      logic [63:0] prod;
      prod = 64'(x) * 64'(m);
      return clsr_pkg::VAL_W'(prod % 64'(n));
   endfunction

   function automatic void reset_generators();
      gen_a      = clsr_pkg::VAL_W'(1);
      gen_b      = clsr_pkg::SEED_B_RESET;
      prev_value = '0;
      foreach (shuffle[i]) shuffle[i] = '0;
   endfunction

   function automatic logic [clsr_pkg::VAL_W-1:0] next_draw(
      input logic                       cmd,
      input logic [clsr_pkg::VAL_W-1:0] seed);
      logic [clsr_pkg::VAL_W-1:0] start;
      longint                     slot;
      longint                     diff;
      if (cmd == clsr_pkg::CMD_RESEED) begin
         start = (seed == '0) ? clsr_pkg::VAL_W'(1) : seed;
         gen_a = start;
         gen_b = start;
         // warm-up steps first, then fill from the last slot down
         for (int i = TBL_DEPTH + clsr_pkg::WARMUP_STEPS - 1; i >= 0; i--) begin
            gen_a = mul_mod(gen_a, clsr_pkg::MUL_A, clsr_pkg::MOD_A);
            if (i < TBL_DEPTH) shuffle[i] = gen_a;
         end
         prev_value = shuffle[0];
      end
      gen_a = mul_mod(gen_a, clsr_pkg::MUL_A, clsr_pkg::MOD_A);
      gen_b = mul_mod(gen_b, clsr_pkg::MUL_B, clsr_pkg::MOD_B);
      slot  = longint'(prev_value) / SLOT_DIV;
      if (slot > TBL_DEPTH - 1) slot = TBL_DEPTH - 1;
      diff = longint'(shuffle[slot]) - longint'(gen_b);
      shuffle[slot] = gen_a;
      if (diff < 1) diff += longint'(clsr_pkg::MOD_A) - 1;
      prev_value = clsr_pkg::VAL_W'(diff);
      return prev_value;
   endfunction

   function automatic void check_value(input logic [clsr_pkg::VAL_W-1:0] actual);
      logic [clsr_pkg::VAL_W-1:0] wanted;
      if (pending_values.size() == 0) begin
         if (errors < PRINT_CAP)
            $display("%0t: unexpected response, expected none, actual %0d", $time, actual);
         errors++;
      end else begin
         wanted = pending_values.pop_front();
         if (actual !== wanted) begin
            if (errors < PRINT_CAP)
               $display("%0t: value mismatch, expected %0d, actual %0d", $time, wanted,
                        actual);
            errors++;
         end
      end
   endfunction

   // response side: random stall bursts and the in-order check
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) check_value(rsp_ch.value);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_request(input logic cmd, input logic [clsr_pkg::VAL_W-1:0] seed);
      logic [clsr_pkg::VAL_W-1:0] predicted;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd   <= cmd;
      req_ch.seed  <= seed;
      @(posedge clock);
      while (!(req_ch.valid && req_ch.ready)) @(posedge clock);
      predicted      = next_draw(cmd, seed);
      pending_values = {pending_values, predicted};
   endtask

   // hold the request side until every response has come back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_values.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
   endtask

   task automatic test_reset_draws();
      repeat (3) send_request(clsr_pkg::CMD_DRAW, clsr_pkg::VAL_W'($urandom));
   endtask

   task automatic test_seed_corners();
      send_request(clsr_pkg::CMD_RESEED, '0);
      send_request(clsr_pkg::CMD_DRAW, '1);
      send_request(clsr_pkg::CMD_RESEED, clsr_pkg::VAL_W'(1));
      send_request(clsr_pkg::CMD_DRAW, '0);
      send_request(clsr_pkg::CMD_RESEED, clsr_pkg::MOD_A - 31'd1);
      // first generator collapses to zero and stays there
      send_request(clsr_pkg::CMD_RESEED, clsr_pkg::MOD_A);
      send_request(clsr_pkg::CMD_DRAW, '0);
      send_request(clsr_pkg::CMD_DRAW, '0);
      // second generator collapses to zero
      send_request(clsr_pkg::CMD_RESEED, clsr_pkg::MOD_B);
      send_request(clsr_pkg::CMD_DRAW, '0);
      send_request(clsr_pkg::CMD_DRAW, '0);
      send_request(clsr_pkg::CMD_RESEED, clsr_pkg::MOD_B + 31'd1);
      send_request(clsr_pkg::CMD_RESEED, '1);
      send_request(clsr_pkg::CMD_DRAW, '0);
      send_request(clsr_pkg::CMD_RESEED, clsr_pkg::VAL_W'(31'h2AAA_AAAA));
      send_request(clsr_pkg::CMD_RESEED, clsr_pkg::VAL_W'(31'h5555_5555));
      send_request(clsr_pkg::CMD_DRAW, '1);
   endtask

   task automatic test_random_mix(input int count);
      logic                       cmd;
      logic [clsr_pkg::VAL_W-1:0] seed;
      for (int n = 0; n < count; n++) begin
         cmd = ($urandom_range(0, 9) == 0) ? clsr_pkg::CMD_RESEED : clsr_pkg::CMD_DRAW;
         case ($urandom_range(0, 11))
            0:       seed = '0;
            1:       seed = clsr_pkg::MOD_A;
            2:       seed = clsr_pkg::MOD_B;
            3:       seed = '1;
            default: seed = clsr_pkg::VAL_W'($urandom);
         endcase
         send_request(cmd, seed);
      end
   endtask

   task automatic test_drain_pause();
      test_random_mix(50);
      wait_drained();
      test_random_mix(50);
   endtask

   task automatic test_quiet_tail();
      idle_on = 1'b0;
      test_random_mix(200);
   endtask

   initial begin
      idle_on      = 1'b1;
      reset_generators();
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.cmd   <= clsr_pkg::CMD_DRAW;
      req_ch.seed  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_draws();
      test_seed_corners();
      test_random_mix(1300);
      test_drain_pause();
      test_quiet_tail();

      wait_drained();
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
